/* design/rotation_matrix_to_quaternion_top_macros.svh */
// Assertion macros shared by the rotation matrix to quaternion design.
// Each macro expects clk and rst_n in scope and reports through $error.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

// Same-cycle implication.
`define RMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rmq_pkg.sv */
// Package for the rotation matrix to quaternion pipeline.
// Holds fixed-point widths, sideband types and the entry saturation function.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int EPS_W     = 15;
  localparam logic [EPS_W-1:0] EPS_RESET = 15'd16;
  localparam int ONE       = 1 << FRAC_BITS;

  // Radicand 1 +/- diagonal terms is at most 4.0.
  localparam int RAD_W     = FRAC_BITS + 3;
  localparam int SUMS_W    = RAD_W + 1;
  localparam int FLAG_W    = DATA_W + 1;
  // First root: radicand scaled by 2^FRAC_BITS, padded to an even width.
  localparam int SQ1_IN_W  = 2 * ((RAD_W + FRAC_BITS + 1) / 2);
  localparam int MAG_W     = SQ1_IN_W / 2;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int LEN_W     = SUM_W / 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DVD_W     = MAG_W + FRAC_BITS + 1;

  localparam logic signed [DATA_W-1:0] ONE_S = DATA_W'(ONE);

  typedef struct packed {
    logic sum21_neg;
    logic sum10_neg;
    logic sum02_neg;
    logic dif21_neg;
    logic dif02_neg;
    logic dif10_neg;
  } sign_flags_t;

  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
  } len_tag_t;

  function automatic logic signed [DATA_W-1:0] sat_entry(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    r = v;
    if (v > ONE_S) begin
      r = ONE_S;
    end else if (v < -ONE_S) begin
      r = -ONE_S;
    end
    return r;
  endfunction

endpackage

/* design/rmq_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband tag alongside; uses no package items.
`timescale 1ns / 1ps

module rmq_sqrt #(
  parameter int LANES = 1,
  parameter int IN_W  = 4,
  parameter int TAG_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][IN_W-1:0]    in_rad,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_valid,
  output logic [LANES-1:0][IN_W/2-1:0]  out_root,
  output logic [TAG_W-1:0]              out_tag
);

  localparam int ROOT_W = IN_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEPS  = ROOT_W;

  logic [STEPS-1:0]               vld_r;
  logic [STEPS-1:0]               vld_nxt;
  logic [LANES-1:0][IN_W-1:0]     opd_r    [STEPS];
  logic [LANES-1:0][REM_W-1:0]    rem_r    [STEPS];
  logic [LANES-1:0][ROOT_W-1:0]   root_r   [STEPS];
  logic [TAG_W-1:0]               tag_r    [STEPS];
  logic [LANES-1:0][IN_W-1:0]     opd_nxt  [STEPS];
  logic [LANES-1:0][REM_W-1:0]    rem_nxt  [STEPS];
  logic [LANES-1:0][ROOT_W-1:0]   root_nxt [STEPS];
  logic [TAG_W-1:0]               tag_nxt  [STEPS];
  logic [LANES-1:0][IN_W-1:0]     opd_src  [STEPS];
  logic [LANES-1:0][REM_W-1:0]    rem_src  [STEPS];
  logic [LANES-1:0][ROOT_W-1:0]   root_src [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign vld_nxt[k]  = in_valid;
      assign opd_src[k]  = in_rad;
      assign rem_src[k]  = '0;
      assign root_src[k] = '0;
      assign tag_nxt[k]  = in_tag;
    end else begin : g_next
      assign vld_nxt[k]  = vld_r[k-1];
      assign opd_src[k]  = opd_r[k-1];
      assign rem_src[k]  = rem_r[k-1];
      assign root_src[k] = root_r[k-1];
      assign tag_nxt[k]  = tag_r[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             ge;

      // Bring down the next two operand bits and try root*4+1.
      assign rem_sh = {rem_src[k][l][REM_W-3:0], opd_src[k][l][IN_W-1 -: 2]};
      assign trial  = {root_src[k][l], 2'b01};
      assign ge     = (rem_sh >= trial);
      assign rem_nxt[k][l]  = ge ? (rem_sh - trial) : rem_sh;
      assign root_nxt[k][l] = {root_src[k][l][ROOT_W-2:0], ge};
      assign opd_nxt[k][l]  = {opd_src[k][l][IN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opd_r  <= opd_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      tag_r  <= tag_nxt;
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_tag   = tag_r[STEPS-1];

endmodule

/* design/rmq_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Lanes share one divisor; a sideband tag travels along. No package items used.
`timescale 1ns / 1ps

module rmq_div #(
  parameter int LANES = 1,
  parameter int N_W   = 4,
  parameter int D_W   = 2,
  parameter int Q_W   = 2,
  parameter int TAG_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][N_W-1:0]   in_num,
  input  logic [D_W-1:0]              in_den,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][Q_W-1:0]   out_quo,
  output logic [D_W-1:0]              out_den,
  output logic [TAG_W-1:0]            out_tag
);

  localparam int CMP_W = D_W + Q_W;

  logic [Q_W-1:0]               vld_r;
  logic [Q_W-1:0]               vld_nxt;
  logic [LANES-1:0][CMP_W-1:0]  rem_r   [Q_W];
  logic [LANES-1:0][Q_W-1:0]    quo_r   [Q_W];
  logic [D_W-1:0]               den_r   [Q_W];
  logic [TAG_W-1:0]             tag_r   [Q_W];
  logic [LANES-1:0][CMP_W-1:0]  rem_nxt [Q_W];
  logic [LANES-1:0][Q_W-1:0]    quo_nxt [Q_W];
  logic [D_W-1:0]               den_nxt [Q_W];
  logic [TAG_W-1:0]             tag_nxt [Q_W];
  logic [LANES-1:0][CMP_W-1:0]  rem_src [Q_W];
  logic [LANES-1:0][Q_W-1:0]    quo_src [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [CMP_W-1:0] dsh;

    if (k == 0) begin : g_first
      assign vld_nxt[k] = in_valid;
      assign den_nxt[k] = in_den;
      assign tag_nxt[k] = in_tag;
      assign quo_src[k] = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_load
        assign rem_src[k][l] = CMP_W'(in_num[l]);
      end
    end else begin : g_next
      assign vld_nxt[k] = vld_r[k-1];
      assign den_nxt[k] = den_r[k-1];
      assign tag_nxt[k] = tag_r[k-1];
      assign quo_src[k] = quo_r[k-1];
      assign rem_src[k] = rem_r[k-1];
    end

    // Stage k settles quotient bit Q_W-1-k.
    assign dsh = CMP_W'(den_nxt[k]) << (Q_W - 1 - k);

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic ge;
      assign ge = (rem_src[k][l] >= dsh);
      assign rem_nxt[k][l] = ge ? (rem_src[k][l] - dsh) : rem_src[k][l];
      assign quo_nxt[k][l] = {quo_src[k][l][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      den_r <= den_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_den   = den_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule

/* design/rotation_matrix_to_quaternion_top.sv */
// Rotation matrix to unit quaternion top level; uses rmq_pkg, rmq_sqrt, rmq_div.
// An accepted beat reaches its result beat through two front
// stages, 16 first-root stages, three stages of sign choice, squaring and sum,
// 17 length-root stages, one dividend stage, 15 divider stages, one output stage.
// Throughput is one beat per cycle; the whole pipeline holds while out_stall backs up.
// Reset clears all valid bits and sets eps_r to 16.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_top_macros.svh"

module rotation_matrix_to_quaternion_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_00,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_01,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_02,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_10,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_11,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_12,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_20,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_21,
  input  logic signed [rmq_pkg::DATA_W-1:0]     in_rot_22,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rmq_pkg::DATA_W-1:0]     out_quat_w,
  output logic signed [rmq_pkg::DATA_W-1:0]     out_quat_x,
  output logic signed [rmq_pkg::DATA_W-1:0]     out_quat_y,
  output logic signed [rmq_pkg::DATA_W-1:0]     out_quat_z,
  input  logic                                  cfg_wr_en,
  input  logic [rmq_pkg::EPS_W-1:0]             cfg_wr_data
);

  localparam int DATA_W   = rmq_pkg::DATA_W;
  localparam int FRAC     = rmq_pkg::FRAC_BITS;
  localparam int SUMS_W   = rmq_pkg::SUMS_W;
  localparam int FLAG_W   = rmq_pkg::FLAG_W;
  localparam int SQ1_IN_W = rmq_pkg::SQ1_IN_W;
  localparam int MAG_W    = rmq_pkg::MAG_W;
  localparam int PROD_W   = rmq_pkg::PROD_W;
  localparam int SUM_W    = rmq_pkg::SUM_W;
  localparam int LEN_W    = rmq_pkg::LEN_W;
  localparam int QUO_W    = rmq_pkg::QUO_W;
  localparam int DVD_W    = rmq_pkg::DVD_W;
  localparam int EPS_W    = rmq_pkg::EPS_W;
  localparam int LTAG_W   = $bits(rmq_pkg::len_tag_t);
  localparam int FTAG_W   = $bits(rmq_pkg::sign_flags_t);
  localparam logic signed [SUMS_W-1:0] ONE_W = SUMS_W'(rmq_pkg::ONE);
  localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(rmq_pkg::ONE);

  logic [EPS_W-1:0] eps_r;
  logic             en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= rmq_pkg::EPS_RESET;
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  // Global advance: everything moves unless a finished beat is held at the output.
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 1: saturate entries.
  logic signed [DATA_W-1:0] raw [9];
  logic signed [DATA_W-1:0] m_r [9];
  logic                     v1_r;

  assign raw[0] = in_rot_00;
  assign raw[1] = in_rot_01;
  assign raw[2] = in_rot_02;
  assign raw[3] = in_rot_10;
  assign raw[4] = in_rot_11;
  assign raw[5] = in_rot_12;
  assign raw[6] = in_rot_20;
  assign raw[7] = in_rot_21;
  assign raw[8] = in_rot_22;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= rmq_pkg::sat_entry(raw[i]);
      end
    end
  end

  // Stage 2: radicands and off-diagonal sign flags.
  logic signed [SUMS_W-1:0]        rs   [4];
  logic signed [SUMS_W-1:0]        d0, d4, d8;
  logic signed [FLAG_W-1:0]        f_s21, f_s10, f_s02, f_d21, f_d02, f_d10;
  logic [3:0][SQ1_IN_W-1:0]        rad_r;
  rmq_pkg::sign_flags_t            flags_r;
  logic                            v2_r;

  assign d0 = SUMS_W'(m_r[0]);
  assign d4 = SUMS_W'(m_r[4]);
  assign d8 = SUMS_W'(m_r[8]);
  assign rs[0] =  d0 + d4 + d8 + ONE_W;
  assign rs[1] =  d0 - d4 - d8 + ONE_W;
  assign rs[2] = -d0 + d4 - d8 + ONE_W;
  assign rs[3] = -d0 - d4 + d8 + ONE_W;

  assign f_s21 = FLAG_W'(m_r[7]) + FLAG_W'(m_r[5]);
  assign f_s10 = FLAG_W'(m_r[3]) + FLAG_W'(m_r[1]);
  assign f_s02 = FLAG_W'(m_r[2]) + FLAG_W'(m_r[6]);
  assign f_d21 = FLAG_W'(m_r[7]) - FLAG_W'(m_r[5]);
  assign f_d02 = FLAG_W'(m_r[2]) - FLAG_W'(m_r[6]);
  assign f_d10 = FLAG_W'(m_r[3]) - FLAG_W'(m_r[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        // A negative radicand is clamped to zero.
        if (rs[i][SUMS_W-1]) begin
          rad_r[i] <= '0;
        end else begin
          rad_r[i] <= SQ1_IN_W'(rs[i][SUMS_W-2:0]) << FRAC;
        end
      end
      flags_r.sum21_neg <= f_s21[FLAG_W-1];
      flags_r.sum10_neg <= f_s10[FLAG_W-1];
      flags_r.sum02_neg <= f_s02[FLAG_W-1];
      flags_r.dif21_neg <= f_d21[FLAG_W-1];
      flags_r.dif02_neg <= f_d02[FLAG_W-1];
      flags_r.dif10_neg <= f_d10[FLAG_W-1];
    end
  end

  // Magnitudes, twice each quaternion component.
  logic                   mag_valid;
  logic [3:0][MAG_W-1:0]  mag;
  logic [FTAG_W-1:0]      mag_tag;
  rmq_pkg::sign_flags_t   mag_flags;

  rmq_sqrt #(
    .LANES (4),
    .IN_W  (SQ1_IN_W),
    .TAG_W (FTAG_W)
  ) u_mag_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_rad    (rad_r),
    .in_tag    (flags_r),
    .out_valid (mag_valid),
    .out_root  (mag),
    .out_tag   (mag_tag)
  );

  assign mag_flags = mag_tag;

  // Stage 3: degenerate cases and signs.
  logic [EPS_W:0]         eps2;
  logic                   w_small, x_small;
  logic [3:0][MAG_W-1:0]  mag3_r;
  logic [3:0]             neg3_r;
  logic                   v3_r;

  assign eps2    = {eps_r, 1'b0};
  assign w_small = (mag[0] < eps2);
  assign x_small = (mag[1] < eps2);

  always_ff @(posedge clk) begin
    if (en) begin
      mag3_r[3:2] <= mag[3:2];
      mag3_r[1]   <= (w_small && x_small) ? '0 : mag[1];
      mag3_r[0]   <= w_small ? '0 : mag[0];
      priority if (w_small && x_small) begin
        neg3_r    <= {mag_flags.sum21_neg, 3'b000};
      end else if (w_small) begin
        neg3_r    <= {mag_flags.sum02_neg, mag_flags.sum10_neg, 2'b00};
      end else begin
        neg3_r    <= {mag_flags.dif10_neg, mag_flags.dif02_neg, mag_flags.dif21_neg, 1'b0};
      end
    end
  end

  // Stage 4: squares.
  logic [3:0][PROD_W-1:0] sq4_r;
  logic [3:0][MAG_W-1:0]  mag4_r;
  logic [3:0]             neg4_r;
  logic                   v4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq4_r[i] <= mag3_r[i] * mag3_r[i];
      end
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
    end
  end

  // Stage 5: sum of squares.
  logic [SUM_W-1:0]       sum5_r;
  rmq_pkg::len_tag_t      ltag5_r;
  logic                   v5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum5_r <= SUM_W'(sq4_r[0]) + SUM_W'(sq4_r[1]) + SUM_W'(sq4_r[2]) + SUM_W'(sq4_r[3]);
      ltag5_r.mag <= mag4_r;
      ltag5_r.neg <= neg4_r;
    end
  end

  // Euclidean length.
  logic                   len_valid;
  logic [0:0][LEN_W-1:0]  len_root;
  logic [LTAG_W-1:0]      len_tag;
  rmq_pkg::len_tag_t      len_info;

  rmq_sqrt #(
    .LANES (1),
    .IN_W  (SUM_W),
    .TAG_W (LTAG_W)
  ) u_len_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_rad    (sum5_r),
    .in_tag    (ltag5_r),
    .out_valid (len_valid),
    .out_root  (len_root),
    .out_tag   (len_tag)
  );

  assign len_info = len_tag;

  // Stage 6: dividends with the half-divisor rounding term.
  logic [3:0][DVD_W-1:0]  num6_r;
  logic [LEN_W-1:0]       den6_r;
  logic [3:0]             neg6_r;
  logic                   v6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num6_r[i] <= (DVD_W'(len_info.mag[i]) << FRAC) + DVD_W'(len_root[0] >> 1);
      end
      den6_r <= len_root[0];
      neg6_r <= len_info.neg;
    end
  end

  logic                   div_valid;
  logic [3:0][QUO_W-1:0]  quo;
  logic [LEN_W-1:0]       div_den;
  logic [3:0]             div_neg;

  rmq_div #(
    .LANES (4),
    .N_W   (DVD_W),
    .D_W   (LEN_W),
    .Q_W   (QUO_W),
    .TAG_W (4)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_num    (num6_r),
    .in_den    (den6_r),
    .in_tag    (neg6_r),
    .out_valid (div_valid),
    .out_quo   (quo),
    .out_den   (div_den),
    .out_tag   (div_neg)
  );

  // Stage 7: zero length check, signs, output register.
  logic [3:0][DATA_W-1:0] outq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (div_den == '0) begin
          outq_r[i] <= '0;
        end else if (div_neg[i]) begin
          outq_r[i] <= -DATA_W'(quo[i]);
        end else begin
          outq_r[i] <= DATA_W'(quo[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= mag_valid;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= len_valid;
      out_valid_r <= div_valid;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = outq_r[0];
  assign out_quat_x = outq_r[1];
  assign out_quat_y = outq_r[2];
  assign out_quat_z = outq_r[3];

  logic len_ok;
  logic quo_ok;

  assign len_ok = (len_root[0] >= len_info.mag[0]) && (len_root[0] >= len_info.mag[1]) &&
                  (len_root[0] >= len_info.mag[2]) && (len_root[0] >= len_info.mag[3]);
  assign quo_ok = (quo[0] <= ONE_Q) && (quo[1] <= ONE_Q) &&
                  (quo[2] <= ONE_Q) && (quo[3] <= ONE_Q);

  `RMQ_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1_r, "accepted beat lost at entry")
  `RMQ_ASSERT_IMPL(a_len_covers_mag, len_valid, len_ok, "length below a magnitude")
  `RMQ_ASSERT_IMPL(a_quo_bound, div_valid && (div_den != '0), quo_ok, "quotient above one")
  `RMQ_ASSERT_IMPL(a_w_nonneg, out_valid_r, !outq_r[0][DATA_W-1], "scalar part negative")

endmodule

/* sim/rotation_matrix_to_quaternion_top_tb.sv */
// Self-checking testbench for the rotation matrix to quaternion pipeline.
// Depends on rmq_pkg, rotation_matrix_to_quaternion_top, rmq_sqrt and rmq_div.
`timescale 1ns / 1ps

class quat_scoreboard;
  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  quat_t pending[$];
  int errors;
  int matched;
  logic [14:0] eps;

  function new();
    errors = 0;
    matched = 0;
    eps = rmq_pkg::EPS_RESET;
  endfunction

  static function longint clamp_entry(logic signed [15:0] raw);
    longint v;
    v = raw;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v;
  endfunction

  static function longint isqrt(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - r - b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  static function longint root_mag(longint s);
    if (s < 0) s = 0;
    return isqrt(s <<< 14);
  endfunction

  function void note_matrix(logic signed [15:0] raw [9]);
    longint m [9];
    longint a [4];
    bit neg [4];
    longint sum, len, q, eps2;
    logic [15:0] o [4];
    quat_t e;
    for (int i = 0; i < 9; i++) m[i] = clamp_entry(raw[i]);
    for (int i = 0; i < 4; i++) neg[i] = 0;
    eps2 = longint'(eps) * 2;
    a[0] = root_mag(m[0] + m[4] + m[8] + 16384);
    a[1] = root_mag(m[0] - m[4] - m[8] + 16384);
    a[2] = root_mag(-m[0] + m[4] - m[8] + 16384);
    a[3] = root_mag(-m[0] - m[4] + m[8] + 16384);
    if (a[0] < eps2 && a[1] < eps2) begin
      a[0] = 0;
      a[1] = 0;
      neg[3] = (m[7] + m[5]) < 0;
    end else if (a[0] < eps2) begin
      a[0] = 0;
      neg[2] = (m[3] + m[1]) < 0;
      neg[3] = (m[2] + m[6]) < 0;
    end else begin
      neg[1] = (m[7] - m[5]) < 0;
      neg[2] = (m[2] - m[6]) < 0;
      neg[3] = (m[3] - m[1]) < 0;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += a[i] * a[i];
    len = isqrt(sum);
    for (int i = 0; i < 4; i++) begin
      q = 0;
      if (len != 0) q = ((a[i] <<< 14) + (len >>> 1)) / len;
      if (neg[i]) q = -q;
      o[i] = q[15:0];
    end
    e.w = o[0];
    e.x = o[1];
    e.y = o[2];
    e.z = o[3];
    pending = {pending, e};
  endfunction

  function void check_quat(logic signed [15:0] w, x, y, z);
    quat_t e;
    if (pending.size() == 0) begin
      $error("result beat with no matrix outstanding");
      errors++;
      return;
    end
    e = pending.pop_front();
    matched++;
    if (w !== e.w) begin
      $error("quat_w expected %0d actual %0d", e.w, w);
      errors++;
    end
    if (x !== e.x) begin
      $error("quat_x expected %0d actual %0d", e.x, x);
      errors++;
    end
    if (y !== e.y) begin
      $error("quat_y expected %0d actual %0d", e.y, y);
      errors++;
    end
    if (z !== e.z) begin
      $error("quat_z expected %0d actual %0d", e.z, z);
      errors++;
    end
  endfunction
endclass

module rotation_matrix_to_quaternion_top_tb;

  localparam int LATENCY = 55;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [rmq_pkg::DATA_W-1:0] rot [9];
  logic out_valid;
  logic out_stall;
  logic signed [rmq_pkg::DATA_W-1:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic cfg_wr_en;
  logic [rmq_pkg::EPS_W-1:0] cfg_wr_data;

  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  bit in_accept;

  quat_scoreboard sb;

  rotation_matrix_to_quaternion_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rot_00(rot[0]), .in_rot_01(rot[1]), .in_rot_02(rot[2]),
    .in_rot_10(rot[3]), .in_rot_11(rot[4]), .in_rot_12(rot[5]),
    .in_rot_20(rot[6]), .in_rot_21(rot[7]), .in_rot_22(rot[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 9; i++) rot[i] = '0;
  end

  // Receiver stall and result checking.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_quat(out_quat_w, out_quat_x, out_quat_y, out_quat_z);
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Valid stays high after a beat so the next one can follow at once;
  // it drops only when the sender idles or drains.
  task automatic send_matrix(input logic signed [15:0] m [9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    rot = m;
    in_valid <= 1;
    do begin
      @(posedge clk);
      in_accept = !in_stall;
    end while (!in_accept);
    sb.note_matrix(m);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_eps(input logic [14:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en <= 1;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.eps = v;
  endtask

  function automatic logic signed [15:0] rand_entry();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'($urandom);          // raw pattern, often saturates
    if (r < 15) return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // Random entries, or more often a near-rotation: signed permutation plus
  // small noise, reaching all three sign cases, the degenerate ones too.
  task automatic send_random(input int count);
    logic signed [15:0] m [9];
    int perm [3];
    int t;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 30) begin
        for (int i = 0; i < 9; i++) m[i] = rand_entry();
      end else begin
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
          int j;
          j = $urandom_range(i);
          t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        for (int i = 0; i < 9; i++)
          m[i] = 16'($signed($urandom_range(64)) - 32);
        for (int r = 0; r < 3; r++)
          m[3 * r + perm[r]] = ($urandom_range(1) ? 16'sd16384 : -16'sd16384)
                               - 16'($urandom_range(40));
      end
      send_matrix(m);
    end
  endtask

  initial begin
    logic signed [15:0] m [9];
    #0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: identity, half turns about each axis, extremes, raw patterns.
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};       send_matrix(m);
    m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};     send_matrix(m);
    m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};     send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};     send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};    send_matrix(m);
    m = '{-16384, 100, -50, -100, -16384, 70, 50, -70, 16384}; send_matrix(m);
    m = '{-16384, -100, 50, -100, -16384, -70, 50, -70, 16384}; send_matrix(m);
    m = '{16384, 200, -300, -200, -16384, -10, 300, -10, -16384}; send_matrix(m);
    m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};      send_matrix(m);
    m = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    send_matrix(m);
    m = '{-32768, 32767, -1, 1, -32768, 16385, -16385, 0, -32768}; send_matrix(m);
    m = '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
          16'h5555, 16'haaaa, 16'h5555};
    send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                   send_matrix(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};           send_matrix(m);

    // Large thresholds zero the w and x magnitudes on some inputs.
    write_eps(15'd16384);
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};       send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};     send_matrix(m);
    send_random(40);
    write_eps(15'h7fff);
    send_random(40);
    write_eps(15'd0);
    send_random(100);

    // The phases of idling.
    write_eps(15'd16);
    send_random(300);
    send_idle_pct = 82;
    write_eps(15'd2000);
    send_random(250);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    send_random(250);
    drain();
    send_idle_pct = 15;
    recv_stall_pct = 15;
    write_eps(15'd300);
    send_random(250);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_eps(15'd1);
    send_random(150);

    drain();
    $display("Ran %0d quaternion beats over thresholds 0 to 32767, with sender", sb.matched);
    $display("gaps and receiver back-pressure; %0d field mismatches.", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/rmq_pkg.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion_top.sv
sim/rotation_matrix_to_quaternion_top_tb.sv
